// File: hdl/wkb_pkg.sv
package wkb_pkg;

  // Result kinds
  localparam logic [1:0] RK_VERTEX    = 2'd0;
  localparam logic [1:0] RK_EMPTY     = 2'd1;
  localparam logic [1:0] RK_BAD_ORDER = 2'd2;
  localparam logic [1:0] RK_BAD_TYPE  = 2'd3;

  // Geometry kinds
  localparam logic [1:0] GK_NONE  = 2'd0;
  localparam logic [1:0] GK_POINT = 2'd1;
  localparam logic [1:0] GK_LINE  = 2'd2;
  localparam logic [1:0] GK_POLY  = 2'd3;

  // Byte-order byte codes
  localparam logic [7:0] ORDER_BIG    = 8'd0;
  localparam logic [7:0] ORDER_LITTLE = 8'd1;

  // Type word codes
  localparam logic [31:0] TYPE_POINT = 32'd1;
  localparam logic [31:0] TYPE_LINE  = 32'd2;
  localparam logic [31:0] TYPE_POLY  = 32'd3;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  geometry_kind;
    logic [31:0] ring_number;
    logic [63:0] x_bits;
    logic [63:0] y_bits;
    logic        last_in_ring;
    logic        last_in_geometry;
  } wkb_result_t;

endpackage

// File: hdl/wkb_geometry_stream_parser_core.sv
// Well-Known Binary geometry parser, one stream byte per beat. A beat with
// in_first_byte set carries the byte-order byte (0 big endian, 1 little
// endian) and restarts parsing, dropping any partial geometry. The 32-bit
// type follows; points, line strings and polygons are decoded, and every
// completed X/Y pair gives one vertex result carrying the raw IEEE double bit
// patterns, the geometry kind, the polygon ring index and last-in-ring /
// last-in-geometry marks. Zero point counts and zero ring counts give an
// empty marker; a bad byte-order byte or any other type (multi types,
// collections) gives an error result and the rest of the stream is ignored
// until the next first byte. The parse state is updated in a single pass of
// logic per accepted beat, so the block sustains one byte per clock while
// in_ready is high. A result appears on the out_ channel the cycle after
// its last byte is accepted when the output register is free; behind a
// stalled result it waits in the skid register until the output register
// drains. An output register plus a one-entry skid register sit on the
// result side, so the input keeps flowing while a result waits; in_ready
// drops only when both are full. Counts are full 32-bit and no stream length
// is checked.
module wkb_geometry_stream_parser_core
  import wkb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [1:0]  out_geometry_kind,
  output logic [31:0] out_ring_number,
  output logic [63:0] out_x_bits,
  output logic [63:0] out_y_bits,
  output logic        out_last_in_ring,
  output logic        out_last_in_geometry
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_NRINGS,
    PH_NPOINTS,
    PH_XCOORD,
    PH_YCOORD
  } phase_t;

  // Parse state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        big_r, big_nxt;
  logic [1:0]  type_r, type_nxt;
  logic [63:0] asm_r, asm_nxt;
  logic [63:0] held_x_r, held_x_nxt;
  logic [31:0] rings_left_r, rings_left_nxt;
  logic [31:0] points_left_r, points_left_nxt;
  logic [31:0] ring_index_r, ring_index_nxt;

  // Result side: output register and skid register
  wkb_result_t out_r, skid_r;
  logic        out_valid_r, skid_valid_r;

  wkb_result_t res;
  logic        res_v;

  logic        in_fire, out_fire;
  logic [63:0] asm_in;
  logic        done4, done8;
  logic [31:0] points_dec, rings_dec;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // Shift the incoming byte into the assembly word in the chosen order.
  assign asm_in = big_r ? {asm_r[55:0], in_data_byte}
                        : (asm_r | (64'(in_data_byte) << {pos_r, 3'b000}));
  assign done4 = (pos_r >= 3'd3);
  assign done8 = (pos_r == 3'd7);

  assign points_dec = points_left_r - 32'd1;
  assign rings_dec  = rings_left_r - 32'd1;

  always_comb begin
    phase_nxt       = phase_r;
    pos_nxt         = pos_r;
    big_nxt         = big_r;
    type_nxt        = type_r;
    asm_nxt         = asm_r;
    held_x_nxt      = held_x_r;
    rings_left_nxt  = rings_left_r;
    points_left_nxt = points_left_r;
    ring_index_nxt  = ring_index_r;
    res             = '0;
    res_v           = 1'b0;

    if (in_fire) begin
      if (in_first_byte) begin
        // Restart: clear everything, then look at the byte-order byte.
        pos_nxt         = '0;
        big_nxt         = 1'b0;
        type_nxt        = GK_NONE;
        asm_nxt         = '0;
        held_x_nxt      = '0;
        rings_left_nxt  = '0;
        points_left_nxt = '0;
        ring_index_nxt  = '0;
        if (in_data_byte == ORDER_BIG) begin
          big_nxt   = 1'b1;
          phase_nxt = PH_TYPE;
        end else if (in_data_byte == ORDER_LITTLE) begin
          phase_nxt = PH_TYPE;
        end else begin
          phase_nxt                 = PH_IDLE;
          res_v                     = 1'b1;
          res.result_kind           = RK_BAD_ORDER;
          res.last_in_geometry      = 1'b1;
        end
      end else begin
        case (phase_r)
          PH_TYPE: begin
            if (!done4) begin
              asm_nxt = asm_in;
              pos_nxt = pos_r + 3'd1;
            end else begin
              asm_nxt = '0;
              pos_nxt = '0;
              if (asm_in[31:0] == TYPE_POINT) begin
                type_nxt        = GK_POINT;
                points_left_nxt = 32'd1;
                phase_nxt       = PH_XCOORD;
              end else if (asm_in[31:0] == TYPE_LINE) begin
                type_nxt  = GK_LINE;
                phase_nxt = PH_NPOINTS;
              end else if (asm_in[31:0] == TYPE_POLY) begin
                type_nxt  = GK_POLY;
                phase_nxt = PH_NRINGS;
              end else begin
                type_nxt             = GK_NONE;
                phase_nxt            = PH_IDLE;
                res_v                = 1'b1;
                res.result_kind      = RK_BAD_TYPE;
                res.last_in_geometry = 1'b1;
              end
            end
          end

          PH_NRINGS: begin
            if (!done4) begin
              asm_nxt = asm_in;
              pos_nxt = pos_r + 3'd1;
            end else begin
              asm_nxt        = '0;
              pos_nxt        = '0;
              rings_left_nxt = asm_in[31:0];
              ring_index_nxt = '0;
              if (asm_in[31:0] == 32'd0) begin
                // Polygon with no rings
                phase_nxt            = PH_IDLE;
                res_v                = 1'b1;
                res.result_kind      = RK_EMPTY;
                res.geometry_kind    = GK_POLY;
                res.last_in_geometry = 1'b1;
              end else begin
                phase_nxt = PH_NPOINTS;
              end
            end
          end

          PH_NPOINTS: begin
            if (!done4) begin
              asm_nxt = asm_in;
              pos_nxt = pos_r + 3'd1;
            end else begin
              asm_nxt         = '0;
              pos_nxt         = '0;
              points_left_nxt = asm_in[31:0];
              if (asm_in[31:0] == 32'd0) begin
                // Empty ring or empty line string: close it with a marker.
                res_v             = 1'b1;
                res.result_kind   = RK_EMPTY;
                res.geometry_kind = type_r;
                res.last_in_ring  = 1'b1;
                if (type_r == GK_POLY) begin
                  res.ring_number      = ring_index_r;
                  rings_left_nxt       = rings_dec;
                  ring_index_nxt       = ring_index_r + 32'd1;
                  res.last_in_geometry = (rings_dec == 32'd0);
                  phase_nxt            = (rings_dec == 32'd0) ? PH_IDLE : PH_NPOINTS;
                end else begin
                  res.last_in_geometry = 1'b1;
                  phase_nxt            = PH_IDLE;
                end
              end else begin
                phase_nxt = PH_XCOORD;
              end
            end
          end

          PH_XCOORD: begin
            if (!done8) begin
              asm_nxt = asm_in;
              pos_nxt = pos_r + 3'd1;
            end else begin
              asm_nxt    = '0;
              pos_nxt    = '0;
              held_x_nxt = asm_in;
              phase_nxt  = PH_YCOORD;
            end
          end

          PH_YCOORD: begin
            if (!done8) begin
              asm_nxt = asm_in;
              pos_nxt = pos_r + 3'd1;
            end else begin
              asm_nxt           = '0;
              pos_nxt           = '0;
              points_left_nxt   = points_dec;
              res_v             = 1'b1;
              res.result_kind   = RK_VERTEX;
              res.geometry_kind = type_r;
              res.x_bits        = held_x_r;
              res.y_bits        = asm_in;
              res.ring_number   = (type_r == GK_POLY) ? ring_index_r : 32'd0;
              if (points_dec != 32'd0) begin
                phase_nxt = PH_XCOORD;
              end else begin
                // Last vertex closes the ring or line.
                res.last_in_ring = 1'b1;
                if (type_r == GK_POLY) begin
                  rings_left_nxt       = rings_dec;
                  ring_index_nxt       = ring_index_r + 32'd1;
                  res.last_in_geometry = (rings_dec == 32'd0);
                  phase_nxt            = (rings_dec == 32'd0) ? PH_IDLE : PH_NPOINTS;
                end else begin
                  res.last_in_geometry = 1'b1;
                  phase_nxt            = PH_IDLE;
                end
              end
            end
          end

          default: begin
            // Idle: drop bytes until the next first byte.
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      pos_r         <= '0;
      big_r         <= 1'b0;
      type_r        <= GK_NONE;
      asm_r         <= '0;
      held_x_r      <= '0;
      rings_left_r  <= '0;
      points_left_r <= '0;
      ring_index_r  <= '0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      pos_r         <= pos_nxt;
      big_r         <= big_nxt;
      type_r        <= type_nxt;
      asm_r         <= asm_nxt;
      held_x_r      <= held_x_nxt;
      rings_left_r  <= rings_left_nxt;
      points_left_r <= points_left_nxt;
      ring_index_r  <= ring_index_nxt;

      if (!out_valid_r || out_fire) begin
        // Output register frees up: advance the skid entry, else the new result.
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= res_v;
        end else begin
          out_valid_r <= res_v;
        end
      end else if (res_v) begin
        // Output stalled: hold the new result in the skid register.
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (res_v) begin
          skid_r <= res;
        end
      end else if (res_v) begin
        out_r <= res;
      end
    end else if (res_v) begin
      skid_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_kind      = out_r.result_kind;
  assign out_geometry_kind    = out_r.geometry_kind;
  assign out_ring_number      = out_r.ring_number;
  assign out_x_bits           = out_r.x_bits;
  assign out_y_bits           = out_r.y_bits;
  assign out_last_in_ring     = out_r.last_in_ring;
  assign out_last_in_geometry = out_r.last_in_geometry;

  // Skid entry is only ever filled behind a waiting output entry.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // Error results always end the geometry and carry no geometry kind.
  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.result_kind == RK_BAD_ORDER || out_r.result_kind == RK_BAD_TYPE)
    |-> out_r.last_in_geometry && (out_r.geometry_kind == GK_NONE))
    else $error("error result with bad field values");

  // A bad byte-order byte parks the parser in idle.
  a_bad_order_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_first_byte && (in_data_byte != ORDER_BIG) && (in_data_byte != ORDER_LITTLE)
    |=> phase_r == PH_IDLE)
    else $error("parser not idle after bad byte order");

  // Only polygons carry a ring number.
  a_ring_only_poly: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.ring_number != 32'd0) |-> out_r.geometry_kind == GK_POLY)
    else $error("ring number on a non-polygon result");

  // Ring count phase only follows a polygon type.
  a_nrings_poly: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_NRINGS) |-> (type_r == GK_POLY))
    else $error("ring count phase without polygon type");

endmodule

// File: tb/sv/tb_wkb_geometry_stream_parser_core.sv
module tb_wkb_geometry_stream_parser_core;
  import wkb_pkg::*;

  // Allow this many cycles with no beat moving on either side before giving up.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Let this many cycles pass after the last result so stray results show up.
  localparam int unsigned TAIL_CYCLES = 20;
  // Count this many parsed beats per random idling phase.
  localparam int unsigned PHASE_BEATS = 140;

  // One beat of the byte stream as the sender presents it.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } stream_beat_t;

  // Parser phases of the local predictor.
  typedef enum logic [2:0] {
    PH_IDLE, PH_TYPE, PH_NRINGS, PH_NPOINTS, PH_XCOORD, PH_YCOORD
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_first_byte = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_kind;
  logic [1:0]  out_geometry_kind;
  logic [31:0] out_ring_number;
  logic [63:0] out_x_bits;
  logic [63:0] out_y_bits;
  logic        out_last_in_ring;
  logic        out_last_in_geometry;

  // Beats waiting to be sent, and parser results waiting to come out.
  stream_beat_t stream_q[$];
  wkb_result_t  wkb_out_q[$];

  int unsigned stim_beats = 0;
  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap_pct = 19;
  int unsigned recv_stall_pct = 73;

  // Predictor state: a private copy of the parser registers.
  parse_phase_t phase_q = PH_IDLE;
  logic [2:0]   byte_pos = 3'd0;
  logic         big_order = 1'b0;
  logic [1:0]   geom_kind = GK_NONE;
  logic [63:0]  asm_word = 64'd0;
  logic [63:0]  x_hold = 64'd0;
  logic [31:0]  rings_left = 32'd0;
  logic [31:0]  points_left = 32'd0;
  logic [31:0]  ring_idx = 32'd0;

  wkb_geometry_stream_parser_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_first_byte        (in_first_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_kind      (out_result_kind),
    .out_geometry_kind    (out_geometry_kind),
    .out_ring_number      (out_ring_number),
    .out_x_bits           (out_x_bits),
    .out_y_bits           (out_y_bits),
    .out_last_in_ring     (out_last_in_ring),
    .out_last_in_geometry (out_last_in_geometry)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Return every parser register to its reset value.
  function automatic void clear_parser();
    phase_q     = PH_IDLE;
    byte_pos    = 3'd0;
    big_order   = 1'b0;
    geom_kind   = GK_NONE;
    asm_word    = 64'd0;
    x_hold      = 64'd0;
    rings_left  = 32'd0;
    points_left = 32'd0;
    ring_idx    = 32'd0;
  endfunction

  // Shift one byte into the assembly word in the chosen order; true once the
  // field of nbytes bytes is complete.
  function automatic bit gather_byte(input logic [7:0] b, input int unsigned nbytes);
    if (big_order) begin
      asm_word = {asm_word[55:0], b};
    end else begin
      asm_word = asm_word | ({56'd0, b} << (8 * byte_pos));
    end
    if (int'(byte_pos) + 1 >= nbytes) begin
      byte_pos = 3'd0;
      return 1'b1;
    end
    byte_pos = byte_pos + 3'd1;
    return 1'b0;
  endfunction

  // Close the current ring or line; true when the whole geometry ends.
  function automatic bit close_ring(output logic [31:0] ring);
    if (geom_kind == GK_POLY) begin
      ring       = ring_idx;
      rings_left = rings_left - 32'd1;
      ring_idx   = ring_idx + 32'd1;
      if (rings_left == 32'd0) begin
        phase_q = PH_IDLE;
        return 1'b1;
      end
      phase_q = PH_NPOINTS;
      return 1'b0;
    end
    ring    = 32'd0;
    phase_q = PH_IDLE;
    return 1'b1;
  endfunction

  // Advance the parser by one stream beat; true when the beat yields a result.
  function automatic bit parse_beat(input logic [7:0] b, input logic fb,
                                    output wkb_result_t r);
    logic [31:0] ring;
    logic [31:0] w32;
    logic [63:0] w64;
    bit          done;
    r = '0;
    // A flagged beat always restarts, dropping any partial geometry.
    if (fb) begin
      clear_parser();
      if (b == ORDER_BIG) begin
        big_order = 1'b1;
        phase_q   = PH_TYPE;
        return 1'b0;
      end
      if (b == ORDER_LITTLE) begin
        phase_q = PH_TYPE;
        return 1'b0;
      end
      r.result_kind      = RK_BAD_ORDER;
      r.last_in_geometry = 1'b1;
      return 1'b1;
    end
    case (phase_q)
      PH_TYPE: begin
        if (!gather_byte(b, 4)) return 1'b0;
        w32      = asm_word[31:0];
        asm_word = 64'd0;
        if (w32 == TYPE_POINT) begin
          geom_kind   = GK_POINT;
          points_left = 32'd1;
          phase_q     = PH_XCOORD;
          return 1'b0;
        end
        if (w32 == TYPE_LINE) begin
          geom_kind = GK_LINE;
          phase_q   = PH_NPOINTS;
          return 1'b0;
        end
        if (w32 == TYPE_POLY) begin
          geom_kind = GK_POLY;
          phase_q   = PH_NRINGS;
          return 1'b0;
        end
        geom_kind          = GK_NONE;
        phase_q            = PH_IDLE;
        r.result_kind      = RK_BAD_TYPE;
        r.last_in_geometry = 1'b1;
        return 1'b1;
      end
      PH_NRINGS: begin
        if (!gather_byte(b, 4)) return 1'b0;
        rings_left = asm_word[31:0];
        asm_word   = 64'd0;
        ring_idx   = 32'd0;
        if (rings_left == 32'd0) begin
          phase_q            = PH_IDLE;
          r.result_kind      = RK_EMPTY;
          r.geometry_kind    = GK_POLY;
          r.last_in_geometry = 1'b1;
          return 1'b1;
        end
        phase_q = PH_NPOINTS;
        return 1'b0;
      end
      PH_NPOINTS: begin
        if (!gather_byte(b, 4)) return 1'b0;
        points_left = asm_word[31:0];
        asm_word    = 64'd0;
        if (points_left == 32'd0) begin
          done               = close_ring(ring);
          r.result_kind      = RK_EMPTY;
          r.geometry_kind    = geom_kind;
          r.ring_number      = ring;
          r.last_in_ring     = 1'b1;
          r.last_in_geometry = done;
          return 1'b1;
        end
        phase_q = PH_XCOORD;
        return 1'b0;
      end
      PH_XCOORD: begin
        if (!gather_byte(b, 8)) return 1'b0;
        x_hold   = asm_word;
        asm_word = 64'd0;
        phase_q  = PH_YCOORD;
        return 1'b0;
      end
      PH_YCOORD: begin
        if (!gather_byte(b, 8)) return 1'b0;
        w64         = asm_word;
        asm_word    = 64'd0;
        points_left = points_left - 32'd1;
        r.result_kind   = RK_VERTEX;
        r.geometry_kind = geom_kind;
        r.x_bits        = x_hold;
        r.y_bits        = w64;
        if (points_left != 32'd0) begin
          phase_q       = PH_XCOORD;
          r.ring_number = (geom_kind == GK_POLY) ? ring_idx : 32'd0;
          return 1'b1;
        end
        done               = close_ring(ring);
        r.ring_number      = ring;
        r.last_in_ring     = 1'b1;
        r.last_in_geometry = done;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stream builders
  // ---------------------------------------------------------------------------

  // Queue a beat that the parser acts on.
  task automatic push_beat(input logic [7:0] b, input logic fb);
    stream_q.push_back('{data: b, first: fb});
    stim_beats++;
  endtask

  // Queue a beat that lands while the parser is idle and is dropped.
  task automatic push_noise(input logic [7:0] b);
    stream_q.push_back('{data: b, first: 1'b0});
  endtask

  task automatic push_word32(input logic [31:0] v, input bit big);
    for (int i = 0; i < 4; i++) begin
      push_beat(big ? v[8*(3-i) +: 8] : v[8*i +: 8], 1'b0);
    end
  endtask

  task automatic push_word64(input logic [63:0] v, input bit big);
    for (int i = 0; i < 8; i++) begin
      push_beat(big ? v[8*(7-i) +: 8] : v[8*i +: 8], 1'b0);
    end
  endtask

  // Byte-order beat plus type word.
  task automatic push_header(input bit big, input logic [31:0] kind_word);
    push_beat(big ? ORDER_BIG : ORDER_LITTLE, 1'b1);
    push_word32(kind_word, big);
  endtask

  // Mostly random doubles, with the all-zero and all-one patterns mixed in.
  function automatic logic [63:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return 64'd0;
    if (pick < 20) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // Count in 0..hi, with zero weighted up so empty cases show up often.
  function automatic int unsigned rand_count(input int unsigned hi);
    if ($urandom_range(99) < 15) return 0;
    return $urandom_range(1, hi);
  endfunction

  // Any type word the parser rejects: multi types, collections, extended codes.
  function automatic logic [31:0] rand_bad_type();
    logic [31:0] t;
    do begin
      case ($urandom_range(3))
        0: t = $urandom_range(7);
        1: t = 32'd1000 + $urandom_range(1, 7);
        2: t = 32'h8000_0000 | $urandom_range(1, 7);
        default: t = $urandom();
      endcase
    end while (t == TYPE_POINT || t == TYPE_LINE || t == TYPE_POLY);
    return t;
  endfunction

  task automatic push_vertices(input bit big, input int unsigned n);
    repeat (n) begin
      push_word64(rand_coord(), big);
      push_word64(rand_coord(), big);
    end
  endtask

  task automatic push_point(input bit big, input logic [63:0] x, input logic [63:0] y);
    push_header(big, TYPE_POINT);
    push_word64(x, big);
    push_word64(y, big);
  endtask

  task automatic push_line(input bit big, input logic [31:0] n);
    push_header(big, TYPE_LINE);
    push_word32(n, big);
    push_vertices(big, n);
  endtask

  task automatic push_ring(input bit big, input logic [31:0] n);
    push_word32(n, big);
    push_vertices(big, n);
  endtask

  // One random geometry: mostly well-formed, the rest errors, cut-off
  // geometries and idle noise.
  task automatic add_random_geometry();
    int unsigned pick;
    int unsigned nrings;
    bit          big;
    big  = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 18) begin
      push_point(big, rand_coord(), rand_coord());
    end else if (pick < 42) begin
      push_line(big, rand_count(5));
    end else if (pick < 72) begin
      nrings = rand_count(3);
      push_header(big, TYPE_POLY);
      push_word32(nrings, big);
      repeat (nrings) push_ring(big, rand_count(3));
    end else if (pick < 79) begin
      push_beat(8'($urandom_range(2, 255)), 1'b1);
    end else if (pick < 86) begin
      push_header(big, rand_bad_type());
    end else if (pick < 94) begin
      // Cut a line string short; the next flagged beat drops it.
      push_header(big, TYPE_LINE);
      push_word32(32'd3, big);
      repeat ($urandom_range(1, 40)) push_beat(8'($urandom_range(255)), 1'b0);
    end else begin
      repeat ($urandom_range(1, 4)) push_noise(8'($urandom_range(255)));
    end
  endtask

  // Hold off the sender until every queued beat is sent and every result seen.
  task automatic wait_drained();
    while (stream_q.size() != 0 || in_valid || wkb_out_q.size() != 0) @(posedge clk);
  endtask

  function automatic string fmt_result(input wkb_result_t r);
    return $sformatf("kind %0d geom %0d ring %0d x %016h y %016h lr %b lg %b",
                     r.result_kind, r.geometry_kind, r.ring_number, r.x_bits,
                     r.y_bits, r.last_in_ring, r.last_in_geometry);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: predict on every accepted beat, then present the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_stream
    wkb_result_t  res;
    stream_beat_t nb;
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_parser();
    end else begin
      if (in_valid && in_ready) begin
        if (parse_beat(in_data_byte, in_first_byte, res)) wkb_out_q.push_back(res);
      end
      // Advance only when the current beat is gone; otherwise hold it.
      if (!in_valid || in_ready) begin
        if (stream_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nb = stream_q.pop_front();
          in_valid      <= 1'b1;
          in_data_byte  <= nb.data;
          in_first_byte <= nb.first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    wkb_result_t got;
    wkb_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_result_kind, out_geometry_kind, out_ring_number, out_x_bits,
               out_y_bits, out_last_in_ring, out_last_in_geometry};
        if (wkb_out_q.size() == 0) begin
          if (fault_count < 10) $display("unexpected result: %s", fmt_result(got));
          fault_count++;
        end else begin
          want = wkb_out_q.pop_front();
          if (got.result_kind !== want.result_kind ||
              got.geometry_kind !== want.geometry_kind ||
              got.ring_number !== want.ring_number ||
              got.x_bits !== want.x_bits ||
              got.y_bits !== want.y_bits ||
              got.last_in_ring !== want.last_in_ring ||
              got.last_in_geometry !== want.last_in_geometry) begin
            if (fault_count < 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
            fault_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : run_stimulus
    int unsigned target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Plain geometries at the coordinate extremes, both byte orders.
    push_point(1'b0, 64'd0, '1);
    push_point(1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    push_line(1'b0, 32'd0);
    push_line(1'b1, 32'd2);
    // Polygon with no rings, then one whose middle and last rings are empty.
    push_header(1'b0, TYPE_POLY);
    push_word32(32'd0, 1'b0);
    push_header(1'b1, TYPE_POLY);
    push_word32(32'd3, 1'b1);
    push_ring(1'b1, 32'd2);
    push_ring(1'b1, 32'd0);
    push_ring(1'b1, 32'd0);
    // Bad byte order; the beats after it are ignored.
    push_beat(8'hFF, 1'b1);
    push_noise(8'h00);
    push_noise(8'hFF);
    push_beat(8'h02, 1'b1);
    // Rejected type words: multipoint, all ones, zero.
    push_header(1'b0, 32'd4);
    push_header(1'b1, 32'hFFFF_FFFF);
    push_header(1'b0, 32'd0);
    // Drop a line string mid-vertex by restarting.
    push_header(1'b0, TYPE_LINE);
    push_word32(32'd2, 1'b0);
    push_word64(rand_coord(), 1'b0);
    repeat (3) push_beat(8'hA5, 1'b0);
    // Full-range counts: follow a few vertices, then restart.
    push_header(1'b1, TYPE_LINE);
    push_word32(32'hFFFF_FFFF, 1'b1);
    push_vertices(1'b1, 2);
    push_header(1'b0, TYPE_POLY);
    push_word32(32'hFFFF_FFFF, 1'b0);
    push_ring(1'b0, 32'd1);
    push_ring(1'b0, 32'd0);
    push_ring(1'b0, 32'd2);
    // Restart again after only the first byte of the type word.
    push_beat(ORDER_LITTLE, 1'b1);
    push_beat(8'h03, 1'b0);
    push_point(1'b0, rand_coord(), rand_coord());
    push_noise(8'h5A);
    wait_drained();

    // Random part in three idling phases; drain between them so the sender
    // sits idle until every result is back.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct   = 19;
          recv_stall_pct = 73;
        end
        1: begin
          send_gap_pct   = 73;
          recv_stall_pct = 19;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      target = stim_beats + PHASE_BEATS;
      while (stim_beats < target) add_random_geometry();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && wkb_out_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
